// ===== rtl/kbdiff_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kbdiff_pkg;

    localparam int KEY_SLOTS = 5;
    localparam int KEY_FIELDS = 5;
    localparam int NSLOT = (KEY_SLOTS < KEY_FIELDS) ? KEY_SLOTS : KEY_FIELDS;
    localparam int MOD_BITS = 8;
    localparam int EVT_MAX = MOD_BITS + 2 * NSLOT;

    // modifier bits in event order 1,0,3,2,6,7,4,5
    localparam logic [MOD_BITS-1:0][2:0] MOD_ORDER =
        {3'd5, 3'd4, 3'd7, 3'd6, 3'd2, 3'd3, 3'd0, 3'd1};

    typedef logic [NSLOT-1:0][7:0] key_arr_t;
    typedef logic [EVT_MAX-1:0] evmask_t;

    typedef struct packed {
        logic [7:0] modifier_bits;
        logic [7:0] key_a;
        logic [7:0] key_b;
        logic [7:0] key_c;
        logic [7:0] key_d;
        logic [7:0] key_e;
        logic [7:0] error_byte;
    } report_t;

    typedef struct packed {
        logic       is_release;
        logic       is_modifier;
        logic [7:0] event_code;
        logic [7:0] modifiers_now;
        logic       last_event;
    } evt_t;

    typedef struct packed {
        logic       is_release;
        logic       is_modifier;
        logic [7:0] code;
    } cand_ev_t;

    typedef struct packed {
        evmask_t                    mask;
        cand_ev_t [EVT_MAX-1:0]     ev;
        logic [7:0]                 mods;
    } cand_t;

    function automatic logic [7:0] slot_key(report_t rep, int slot);
        logic [7:0] k;
        case (slot)
            0: k = rep.key_a;
            1: k = rep.key_b;
            2: k = rep.key_c;
            3: k = rep.key_d;
            4: k = rep.key_e;
            default: k = 8'h00;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/kbdiff_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kbdiff_lane (
    input  wire logic [7:0]          key,
    input  wire kbdiff_pkg::key_arr_t others,
    output logic                     hit
);

    logic found;

    always_comb
    begin
        found = 1'b0;
        for (int j = 0; j < kbdiff_pkg::NSLOT; j++)
        begin
            if (others[j] == key)
            begin
                found = 1'b1;
            end
        end
        hit = (key != 8'h00) && !found;
    end

endmodule

`default_nettype wire

// ===== rtl/kbdiff_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kbdiff_merge (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load_valid,
    output logic                   load_stall,
    input  wire kbdiff_pkg::cand_t cand,
    output logic                   evt_valid,
    input  wire logic              evt_stall,
    output kbdiff_pkg::evt_t       evt
);

    kbdiff_pkg::evmask_t                       mask_reg, mask_next;
    kbdiff_pkg::cand_ev_t [kbdiff_pkg::EVT_MAX-1:0] ev_reg, ev_next;
    logic [7:0]                                mods_reg, mods_next;
    logic                                      out_valid_reg, out_valid_next;
    kbdiff_pkg::evt_t                          out_reg, out_next;

    kbdiff_pkg::evmask_t pick, rest, mask_after;
    kbdiff_pkg::cand_ev_t sel;
    logic out_free, pop, load;

    assign out_free   = !out_valid_reg || !evt_stall;
    assign pop        = out_free && (|mask_reg);
    assign pick       = mask_reg & (~mask_reg + kbdiff_pkg::evmask_t'(1));
    assign rest       = mask_reg & ~pick;
    assign mask_after = pop ? rest : mask_reg;
    assign load_stall = |mask_after;
    assign load       = load_valid && !load_stall;

    always_comb
    begin
        sel = '0;
        for (int i = 0; i < kbdiff_pkg::EVT_MAX; i++)
        begin
            if (pick[i])
            begin
                sel = sel | ev_reg[i];
            end
        end
    end

    always_comb
    begin
        mask_next      = load ? cand.mask : mask_after;
        ev_next        = load ? cand.ev : ev_reg;
        mods_next      = load ? cand.mods : mods_reg;
        out_valid_next = pop ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);
        out_next       = out_reg;
        if (pop)
        begin
            out_next.is_release    = sel.is_release;
            out_next.is_modifier   = sel.is_modifier;
            out_next.event_code    = sel.code;
            out_next.modifiers_now = mods_reg;
            out_next.last_event    = (rest == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg   <= ev_next;
        mods_reg <= mods_next;
        out_reg  <= out_next;
    end

    assign evt_valid = out_valid_reg;
    assign evt       = out_reg;

    a_pick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> $onehot(pick))
        else $error("pending event pick not one-hot");

    a_load_mask: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (mask_reg == $past(cand.mask)))
        else $error("event mask not captured on load");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (mask_reg == '0) |-> !load_stall)
        else $error("stall with no pending events");

    a_drain_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && rest != '0) |=> (out_valid_reg && !out_reg.last_event))
        else $error("last flag set with events pending");

endmodule

`default_nettype wire

// ===== rtl/keyboard_report_diff_events.sv =====
// Keyboard report differencer.
// report channel (report_valid / report_stall / report) takes one boot keyboard
// report per transaction. evt channel (evt_valid / evt_stall / evt) gives one
// press or release event per transaction: modifier edges first, then new keys,
// then released keys; last_event marks the final event of a report.
// A report with a nonzero error_byte is taken, gives no events and leaves the
// stored report unchanged. A report equal to the stored one gives no events.
// A taken report's first event passes the pending event mask register, then the
// output register. A report giving N events holds the event sequencer until
// all have left, one event per cycle while the receiver does not stall (up to
// 18); the next report is taken in the cycle the last event of the previous
// one moves out, so unstalled reports of one event or none flow one per cycle.
// When the receiver stalls, the output register holds its event and the
// sequencer, and then report_stall, back up behind it.
// Reset clears the stored report to all zero and drops pending events.
`timescale 1ns / 1ps
`default_nettype none

module keyboard_report_diff_events (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                report_valid,
    output logic                     report_stall,
    input  wire kbdiff_pkg::report_t report,
    output logic                     evt_valid,
    input  wire logic                evt_stall,
    output kbdiff_pkg::evt_t         evt
);

    logic [7:0]           prev_mod_reg, prev_mod_next;
    kbdiff_pkg::key_arr_t prev_keys_reg, prev_keys_next;
    kbdiff_pkg::key_arr_t cur_keys;
    kbdiff_pkg::cand_t    cand;
    logic [kbdiff_pkg::NSLOT-1:0] press_hit, release_hit;
    logic err, accept;

    assign err    = (report.error_byte != 8'h00);
    assign accept = report_valid && !report_stall;

    always_comb
    begin
        for (int i = 0; i < kbdiff_pkg::NSLOT; i++)
        begin
            cur_keys[i] = kbdiff_pkg::slot_key(report, i);
        end
    end

    for (genvar p = 0; p < kbdiff_pkg::NSLOT; p++)
    begin : g_lane
        kbdiff_lane u_press (
            .key    (cur_keys[p]),
            .others (prev_keys_reg),
            .hit    (press_hit[p])
        );
        kbdiff_lane u_release (
            .key    (prev_keys_reg[p]),
            .others (cur_keys),
            .hit    (release_hit[p])
        );
    end

    always_comb
    begin
        logic [2:0] b;
        cand      = '0;
        cand.mods = report.modifier_bits;
        for (int m = 0; m < kbdiff_pkg::MOD_BITS; m++)
        begin
            b = kbdiff_pkg::MOD_ORDER[m];
            cand.mask[m] = !err && (report.modifier_bits[b] != prev_mod_reg[b]);
            cand.ev[m].is_release  = prev_mod_reg[b];
            cand.ev[m].is_modifier = 1'b1;
            cand.ev[m].code        = {5'd0, b};
        end
        for (int p = 0; p < kbdiff_pkg::NSLOT; p++)
        begin
            cand.mask[kbdiff_pkg::MOD_BITS + p] = !err && press_hit[p];
            cand.ev[kbdiff_pkg::MOD_BITS + p].is_release  = 1'b0;
            cand.ev[kbdiff_pkg::MOD_BITS + p].is_modifier = 1'b0;
            cand.ev[kbdiff_pkg::MOD_BITS + p].code        = cur_keys[p];
            cand.mask[kbdiff_pkg::MOD_BITS + kbdiff_pkg::NSLOT + p] =
                !err && release_hit[p];
            cand.ev[kbdiff_pkg::MOD_BITS + kbdiff_pkg::NSLOT + p].is_release  = 1'b1;
            cand.ev[kbdiff_pkg::MOD_BITS + kbdiff_pkg::NSLOT + p].is_modifier = 1'b0;
            cand.ev[kbdiff_pkg::MOD_BITS + kbdiff_pkg::NSLOT + p].code =
                prev_keys_reg[p];
        end
    end

    always_comb
    begin
        prev_mod_next  = prev_mod_reg;
        prev_keys_next = prev_keys_reg;
        if (accept && !err)
        begin
            prev_mod_next  = report.modifier_bits;
            prev_keys_next = cur_keys;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_mod_reg  <= '0;
            prev_keys_reg <= '0;
        end
        else
        begin
            prev_mod_reg  <= prev_mod_next;
            prev_keys_reg <= prev_keys_next;
        end
    end

    kbdiff_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (report_valid),
        .load_stall (report_stall),
        .cand       (cand),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .evt        (evt)
    );

    a_err_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && err) |=> (prev_mod_reg == $past(prev_mod_reg)
                             && prev_keys_reg == $past(prev_keys_reg)))
        else $error("error report changed stored state");

    a_err_no_events: assert property (@(posedge clk) disable iff (!rst_n)
        err |-> (cand.mask == '0))
        else $error("error report produced events");

    a_store_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !err) |=> (prev_mod_reg == $past(report.modifier_bits)))
        else $error("stored modifiers not updated");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        kbdiff_pkg::report_t rep;
        int                  n_typed;
        kbdiff_pkg::evt_t    typed_ev;
    } dir_row_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE,
        STALL_HOLD
    } stall_mode_t;

    localparam int RANDOM_REPORTS = 340;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;
    // modifier bits in event order 1,0,3,2,6,7,4,5 (slot 0 in the low bits)
    localparam logic [23:0] MOD_SEQ = {3'd5, 3'd4, 3'd7, 3'd6, 3'd2, 3'd3, 3'd0, 3'd1};

    logic                clk;
    logic                rst_n;
    logic                report_valid;
    logic                report_stall;
    kbdiff_pkg::report_t report;
    logic                evt_valid;
    logic                evt_stall;
    kbdiff_pkg::evt_t    evt;

    logic [7:0]       stored_mods;
    logic [7:0]       stored_keys [5];
    kbdiff_pkg::evt_t pending_events [$];
    dir_row_t         dir_rows [$];
    kbdiff_pkg::evt_t expected_evt;
    int               error_count;
    int               burst_left;
    bit               hold_request;

    keyboard_report_diff_events uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report       (report),
        .evt_valid    (evt_valid),
        .evt_stall    (evt_stall),
        .evt          (evt)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic kbdiff_pkg::report_t make_rep(input logic [7:0] mods,
                                                     input logic [7:0] ka,
                                                     input logic [7:0] kb,
                                                     input logic [7:0] kc,
                                                     input logic [7:0] kd,
                                                     input logic [7:0] ke,
                                                     input logic [7:0] err);
        kbdiff_pkg::report_t r;
        r.modifier_bits = mods;
        r.key_a = ka;
        r.key_b = kb;
        r.key_c = kc;
        r.key_d = kd;
        r.key_e = ke;
        r.error_byte = err;
        return r;
    endfunction

    function automatic kbdiff_pkg::evt_t make_event(input logic rel, input logic is_mod,
                                                    input logic [7:0] code,
                                                    input logic [7:0] mods,
                                                    input logic last);
        kbdiff_pkg::evt_t e;
        e.is_release = rel;
        e.is_modifier = is_mod;
        e.event_code = code;
        e.modifiers_now = mods;
        e.last_event = last;
        return e;
    endfunction

    function automatic kbdiff_pkg::report_t random_report();
        return make_rep(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
    endfunction

    // mostly a small pool so keys overlap between reports
    function automatic logic [7:0] pool_key();
        int r;
        logic [7:0] k;
        r = $urandom_range(0, 9);
        if (r < 2)
            k = 8'h00;
        else if (r < 8)
            k = 8'h04 + 8'($urandom_range(0, 7));
        else
            k = 8'($urandom_range(1, 255));
        return k;
    endfunction

    // expected events of one report; updates the stored report unless error_byte is nonzero
    function automatic void apply_report(input kbdiff_pkg::report_t rep,
                                         input bit push_events);
        logic [7:0]       new_keys [5];
        kbdiff_pkg::evt_t evs [kbdiff_pkg::EVT_MAX];
        int               n;
        int               bit_idx;
        bit               found;
        logic             now_set;
        logic             was_set;
        if (rep.error_byte != 8'h00)
            return;
        new_keys[0] = rep.key_a;
        new_keys[1] = rep.key_b;
        new_keys[2] = rep.key_c;
        new_keys[3] = rep.key_d;
        new_keys[4] = rep.key_e;
        n = 0;
        for (int i = 0; i < kbdiff_pkg::MOD_BITS; i++)
        begin
            bit_idx = MOD_SEQ[i*3 +: 3];
            now_set = rep.modifier_bits[bit_idx];
            was_set = stored_mods[bit_idx];
            if (now_set && !was_set)
            begin
                evs[n] = make_event(1'b0, 1'b1, 8'(bit_idx), rep.modifier_bits, 1'b0);
                n++;
            end
            else if (!now_set && was_set)
            begin
                evs[n] = make_event(1'b1, 1'b1, 8'(bit_idx), rep.modifier_bits, 1'b0);
                n++;
            end
        end
        for (int i = 0; i < kbdiff_pkg::NSLOT; i++)
        begin
            found = 1'b0;
            for (int j = 0; j < kbdiff_pkg::NSLOT; j++)
                if (stored_keys[j] == new_keys[i])
                    found = 1'b1;
            if (new_keys[i] != 8'h00 && !found)
            begin
                evs[n] = make_event(1'b0, 1'b0, new_keys[i], rep.modifier_bits, 1'b0);
                n++;
            end
        end
        for (int i = 0; i < kbdiff_pkg::NSLOT; i++)
        begin
            found = 1'b0;
            for (int j = 0; j < kbdiff_pkg::NSLOT; j++)
                if (new_keys[j] == stored_keys[i])
                    found = 1'b1;
            if (stored_keys[i] != 8'h00 && !found)
            begin
                evs[n] = make_event(1'b1, 1'b0, stored_keys[i], rep.modifier_bits, 1'b0);
                n++;
            end
        end
        if (n > 0)
            evs[n-1].last_event = 1'b1;
        if (push_events)
            for (int i = 0; i < n; i++)
                pending_events.push_back(evs[i]);
        stored_mods = rep.modifier_bits;
        for (int i = 0; i < kbdiff_pkg::NSLOT; i++)
            stored_keys[i] = new_keys[i];
    endfunction

    function automatic kbdiff_pkg::report_t next_report();
        logic [7:0] mods;
        logic [7:0] keys [5];
        logic [7:0] err;
        int         kind;
        kind = $urandom_range(0, 99);
        mods = stored_mods;
        for (int i = 0; i < 5; i++)
            keys[i] = stored_keys[i];
        err = 8'h00;
        if (kind < 10)
        begin
            // error report, content random
            mods = 8'($urandom_range(0, 255));
            for (int i = 0; i < 5; i++)
                keys[i] = 8'($urandom_range(0, 255));
            err = 8'($urandom_range(1, 255));
        end
        else if (kind < 18)
        begin
            // repeat of the stored report
        end
        else if (kind < 50)
        begin
            repeat ($urandom_range(0, 2))
                mods[$urandom_range(0, 7)] = ~mods[$urandom_range(0, 7)];
            repeat ($urandom_range(1, 2))
                keys[$urandom_range(0, 4)] = pool_key();
        end
        else if (kind < 75)
        begin
            mods = 8'($urandom_range(0, 255));
            for (int i = 0; i < 5; i++)
                keys[i] = pool_key();
        end
        else if (kind < 92)
        begin
            mods = 8'($urandom_range(0, 255));
            for (int i = 0; i < 5; i++)
                keys[i] = 8'($urandom_range(0, 255));
        end
        else
        begin
            mods = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
            for (int i = 0; i < 5; i++)
                keys[i] = 8'h00;
        end
        return make_rep(mods, keys[0], keys[1], keys[2], keys[3], keys[4], err);
    endfunction

    task automatic add_row(input kbdiff_pkg::report_t rep, input int n_typed,
                           input kbdiff_pkg::evt_t ev);
        dir_row_t row;
        row.rep = rep;
        row.n_typed = n_typed;
        row.typed_ev = ev;
        dir_rows.push_back(row);
    endtask

    // n_typed < 0: predictor gives the events; otherwise the typed ones are used
    task automatic send_report(input kbdiff_pkg::report_t rep, input int n_typed,
                               input kbdiff_pkg::evt_t ev);
        report_valid <= 1'b1;
        report <= rep;
        @(posedge clk);
        while (report_stall)
            @(posedge clk);
        if (n_typed < 0)
            apply_report(rep, 1'b1);
        else
        begin
            apply_report(rep, 1'b0);
            if (n_typed > 0)
                pending_events.push_back(ev);
        end
    endtask

    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 9))
                0: gap = 0;
                1: gap = $urandom_range(15, 40);
                default: gap = $urandom_range(1, 5);
            endcase
            if (gap > 0)
            begin
                report_valid <= 1'b0;
                report <= random_report();
                repeat (gap)
                    @(posedge clk);
            end
        end
    endtask

    // receiver stall pattern
    initial
    begin
        stall_mode_t mode;
        int          seg_len;
        evt_stall = 1'b0;
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 3));
            seg_len = $urandom_range(10, 80);
            if (hold_request)
            begin
                hold_request = 1'b0;
                mode = STALL_HOLD;
                seg_len = HOLD_CYCLES;
            end
            for (int c = 0; c < seg_len; c++)
            begin
                @(posedge clk);
                case (mode)
                    STALL_NONE:   evt_stall <= 1'b0;
                    STALL_LIGHT:  evt_stall <= ($urandom_range(0, 99) < 25);
                    STALL_HEAVY:  evt_stall <= ($urandom_range(0, 99) < 70);
                    STALL_TOGGLE: evt_stall <= c[0];
                    default:      evt_stall <= 1'b1;
                endcase
            end
        end
    end

    // event checker
    always @(posedge clk)
    begin
        if (rst_n && evt_valid && !evt_stall)
        begin
            if (pending_events.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected event rel=%0d mod=%0d code=%02h mods=%02h last=%0d",
                         $time, evt.is_release, evt.is_modifier, evt.event_code,
                         evt.modifiers_now, evt.last_event);
            end
            else
            begin
                expected_evt = pending_events.pop_front();
                if (evt.is_release !== expected_evt.is_release ||
                    evt.is_modifier !== expected_evt.is_modifier ||
                    evt.event_code !== expected_evt.event_code ||
                    evt.modifiers_now !== expected_evt.modifiers_now ||
                    evt.last_event !== expected_evt.last_event)
                begin
                    error_count++;
                    $display("%0t: mismatch expected rel=%0d mod=%0d code=%02h mods=%02h last=%0d",
                             $time, expected_evt.is_release, expected_evt.is_modifier,
                             expected_evt.event_code, expected_evt.modifiers_now,
                             expected_evt.last_event);
                    $display("%0t:          actual   rel=%0d mod=%0d code=%02h mods=%02h last=%0d",
                             $time, evt.is_release, evt.is_modifier, evt.event_code,
                             evt.modifiers_now, evt.last_event);
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("** keyboard_report_diff_events: FAILED **");
        $finish;
    end

    initial
    begin
        kbdiff_pkg::evt_t    no_evt;
        kbdiff_pkg::report_t rep;
        int                  counted;
        rst_n = 1'b0;
        report_valid = 1'b0;
        report = '0;
        error_count = 0;
        burst_left = 1;
        hold_request = 1'b0;
        stored_mods = 8'h00;
        for (int i = 0; i < 5; i++)
            stored_keys[i] = 8'h00;
        no_evt = '0;

        add_row(make_rep(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 0, no_evt);
        add_row(make_rep(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 0, no_evt);
        add_row(make_rep(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01), 0, no_evt);
        add_row(make_rep(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1,
                make_event(1'b0, 1'b1, 8'h00, 8'h01, 1'b1));
        add_row(make_rep(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1,
                make_event(1'b1, 1'b1, 8'h00, 8'h00, 1'b1));
        add_row(make_rep(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), -1, no_evt);
        add_row(make_rep(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), -1, no_evt);
        add_row(make_rep(8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1,
                make_event(1'b0, 1'b0, 8'hFF, 8'h00, 1'b1));
        add_row(make_rep(8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 0, no_evt);
        add_row(make_rep(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1,
                make_event(1'b1, 1'b0, 8'hFF, 8'h00, 1'b1));
        add_row(make_rep(8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00), -1, no_evt);
        add_row(make_rep(8'hFF, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h00), -1, no_evt);
        add_row(make_rep(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80), 0, no_evt);
        add_row(make_rep(8'h55, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h00), -1, no_evt);
        add_row(make_rep(8'h55, 8'h07, 8'h07, 8'h07, 8'h00, 8'h00, 8'h00), -1, no_evt);
        add_row(make_rep(8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), -1, no_evt);
        add_row(make_rep(8'h00, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h00), -1, no_evt);
        add_row(make_rep(8'hFF, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h00), -1, no_evt);
        add_row(make_rep(8'h00, 8'hFF, 8'hFE, 8'h80, 8'h7F, 8'h01, 8'h00), -1, no_evt);
        add_row(make_rep(8'h00, 8'h01, 8'hFF, 8'h7F, 8'h80, 8'hFE, 8'h00), -1, no_evt);
        add_row(make_rep(8'h00, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h00), -1, no_evt);
        add_row(make_rep(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), -1, no_evt);

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_report(dir_rows[i].rep, dir_rows[i].n_typed, dir_rows[i].typed_ev);
            pace_sender();
        end

        // long receiver hold at the start and halfway through
        hold_request = 1'b1;
        counted = 0;
        while (counted < RANDOM_REPORTS)
        begin
            rep = next_report();
            send_report(rep, -1, no_evt);
            counted++;
            if (counted == RANDOM_REPORTS / 2)
                hold_request = 1'b1;
            pace_sender();
        end

        report_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (error_count == 0 && pending_events.size() == 0)
            $display("** keyboard_report_diff_events: PASSED **");
        else
            $display("** keyboard_report_diff_events: FAILED **");
        $finish;
    end

endmodule

// ===== keyboard_report_diff_events.f =====
rtl/kbdiff_pkg.sv
rtl/kbdiff_lane.sv
rtl/kbdiff_merge.sv
rtl/keyboard_report_diff_events.sv
verif/tb_top.sv
